FILE: sv/pnf_pkg.sv
// Package for the printf number formatter: opcode and base codes, record types.
// No dependencies.
`default_nettype none
package pnf_pkg;
  localparam logic [3:0] OP_PCT  = 4'd0;
  localparam logic [3:0] OP_CHR  = 4'd1;
  localparam logic [3:0] OP_SDEC = 4'd2;
  localparam logic [3:0] OP_OCT  = 4'd3;
  localparam logic [3:0] OP_UDEC = 4'd4;
  localparam logic [3:0] OP_PTR  = 4'd5;
  localparam logic [3:0] OP_AHXL = 4'd6;
  localparam logic [3:0] OP_AHXU = 4'd7;
  localparam logic [3:0] OP_HXL  = 4'd8;
  localparam logic [3:0] OP_HXU  = 4'd9;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam int NDIG = 11;

  typedef struct packed {
    logic       single;
    logic [7:0] single_ch;
    logic       neg;
    logic       pfx;
    logic       upper;
    logic [1:0] base;
    logic [31:0] mag;
    logic [5:0] width;
    logic       pad_zero;
    logic       left;
  } req_t;

  typedef struct packed {
    logic       single;
    logic [7:0] single_ch;
    logic       neg;
    logic       pfx;
    logic       upper;
    logic [5:0] width;
    logic       pad_zero;
    logic       left;
  } hdr_t;
endpackage
`default_nettype wire

FILE: sv/pnf_decode.sv
// Decode stage: classifies the request, takes the magnitude, saturates width.
// Depends on pnf_pkg.
`default_nettype none
module pnf_decode import pnf_pkg::*; #(
  parameter int MAX_W = 62
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        v_in,
  input  wire logic [3:0]  opcode,
  input  wire logic [31:0] value,
  input  wire logic [5:0]  field_width,
  input  wire logic        pad_zero,
  input  wire logic        left_justify,
  output logic             v_r,
  output req_t             q_r
);
  req_t q_nxt;
  logic ok;
  always_comb begin
    q_nxt = '0;
    ok = 1'b1;
    q_nxt.mag = value;
    q_nxt.width = (field_width > 6'(MAX_W)) ? 6'(MAX_W) : field_width;
    q_nxt.pad_zero = pad_zero;
    q_nxt.left = left_justify;
    q_nxt.single_ch = value[7:0];
    case (opcode)
      OP_PCT: begin q_nxt.single = 1'b1; q_nxt.single_ch = 8'h25; end
      OP_CHR: q_nxt.single = 1'b1;
      OP_SDEC: begin
        q_nxt.neg = value[31];
        q_nxt.mag = value[31] ? (32'd0 - value) : value;
      end
      OP_OCT: q_nxt.base = BASE_OCT;
      OP_UDEC: q_nxt.base = BASE_DEC;
      OP_PTR, OP_AHXL: begin q_nxt.base = BASE_HEX; q_nxt.pfx = 1'b1; end
      OP_AHXU: begin q_nxt.base = BASE_HEX; q_nxt.pfx = 1'b1; q_nxt.upper = 1'b1; end
      OP_HXL: q_nxt.base = BASE_HEX;
      OP_HXU: begin q_nxt.base = BASE_HEX; q_nxt.upper = 1'b1; end
      default: ok = 1'b0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= v_in & ok;
    if (en) q_r <= q_nxt;
  end
endmodule
`default_nettype wire

FILE: sv/pnf_digits.sv
// Digit pipeline: one digit per stage, least significant first, then count.
// Depends on pnf_pkg.
`default_nettype none
module pnf_digits import pnf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       v_in,
  input  req_t            d_in,
  output logic            v_out,
  output hdr_t            h_out,
  output logic [NDIG*4-1:0] dig_out,
  output logic [3:0]      ndig_out
);
  logic [NDIG:0] v_r;
  req_t          q_r [NDIG+1];
  logic [31:0]   rem_r [NDIG+1];
  logic [NDIG*4-1:0] dg_r [NDIG+1];
  logic [3:0]    nd_r [NDIG+1];

  assign q_r[0] = d_in;
  assign rem_r[0] = d_in.mag;
  assign dg_r[0] = '0;
  assign nd_r[0] = 4'd1;

  for (genvar s = 0; s < NDIG; s++) begin : g_st
    logic [31:0] quo, r_nxt;
    logic [3:0]  dig;
    logic [63:0] prod;
    always_comb begin
      prod = {32'd0, rem_r[s]} * 64'h00000000CCCCCCCD;
      case (q_r[s].base)
        BASE_OCT: begin quo = rem_r[s] >> 3; dig = {1'b0, rem_r[s][2:0]}; end
        BASE_HEX: begin quo = rem_r[s] >> 4; dig = rem_r[s][3:0]; end
        default: begin
          quo = {3'd0, prod[63:35]};
          dig = 4'(rem_r[s] - quo * 32'd10);
        end
      endcase
      r_nxt = quo;
    end
    logic vs_r;
    req_t qs_r;
    logic [31:0] rs_r;
    logic [NDIG*4-1:0] ds_r;
    logic [3:0] ns_r;
    always_ff @(posedge clk) begin
      if (!rst_n) vs_r <= 1'b0;
      else if (en) vs_r <= (s == 0) ? v_in : v_r[s];
      if (en) begin
        qs_r <= q_r[s];
        rs_r <= r_nxt;
        ds_r <= dg_r[s] | ((NDIG*4)'(dig) << (4 * s));
        ns_r <= (s != 0 && rem_r[s] != 32'd0) ? 4'(s + 1) : nd_r[s];
      end
    end
    assign v_r[s+1] = vs_r;
    assign q_r[s+1] = qs_r;
    assign rem_r[s+1] = rs_r;
    assign dg_r[s+1] = ds_r;
    assign nd_r[s+1] = ns_r;
  end
  assign v_r[0] = v_in;

  assign v_out = v_r[NDIG];
  assign h_out = '{single: q_r[NDIG].single, single_ch: q_r[NDIG].single_ch,
                   neg: q_r[NDIG].neg, pfx: q_r[NDIG].pfx, upper: q_r[NDIG].upper,
                   width: q_r[NDIG].width, pad_zero: q_r[NDIG].pad_zero,
                   left: q_r[NDIG].left};
  assign dig_out = dg_r[NDIG];
  assign ndig_out = nd_r[NDIG];
endmodule
`default_nettype wire

FILE: sv/pnf_emit.sv
// Character sequencer: walks prefix, padding, sign and digits of one item.
// Depends on pnf_pkg.
`default_nettype none
module pnf_emit import pnf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       v_in,
  input  hdr_t            h_in,
  input  wire logic [NDIG*4-1:0] dig_in,
  input  wire logic [3:0] ndig_in,
  output logic            take,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_character,
  output logic            out_last
);
  logic        busy_r;
  hdr_t        h_r;
  logic [NDIG*4-1:0] dg_r;
  logic [6:0]  pos_r, pos_nxt, tot_r;
  logic [6:0]  body_r, padn_r, pfxn_r;
  logic [6:0]  blen, padn, k, j;
  logic [3:0]  d;
  logic [7:0]  ch, pch;
  logic        ov_r;
  logic [7:0]  oc_r;
  logic        ol_r;
  logic        adv;

  assign adv = busy_r && (!ov_r || !out_stall);
  assign take = !busy_r || (adv && pos_r + 7'd1 == tot_r);

  always_comb begin
    blen = 7'(ndig_in) + {6'd0, h_in.neg};
    padn = ({1'b0, h_in.width} > blen) ? {1'b0, h_in.width} - blen : 7'd0;
    pch = h_r.pad_zero ? 8'h30 : 8'h20;
    k = pos_r - pfxn_r;
    if (!h_r.left) k = k - padn_r;
    j = body_r - 7'd1 - k;
    d = dg_r[4 * j[3:0] +: 4];
    if (d < 4'd10) ch = 8'h30 + {4'd0, d};
    else ch = (h_r.upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
    if (h_r.single) ch = h_r.single_ch;
    else if (pos_r < pfxn_r) ch = (pos_r == 7'd0) ? 8'h30 : (h_r.upper ? 8'h58 : 8'h78);
    else if (!h_r.left && pos_r < pfxn_r + padn_r) ch = pch;
    else if (k >= body_r) ch = pch;
    else if (h_r.neg && k == 7'd0) ch = 8'h2d;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (adv) pos_nxt = pos_r + 7'd1;
    if (take && v_in) pos_nxt = 7'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (!ov_r || !out_stall) ov_r <= adv;
      if (take) busy_r <= v_in;
    end
    pos_r <= pos_nxt;
    if (adv) begin
      oc_r <= ch;
      ol_r <= (pos_r + 7'd1 == tot_r);
    end
    if (take && v_in) begin
      h_r <= h_in;
      dg_r <= dig_in;
      body_r <= blen;
      padn_r <= padn;
      pfxn_r <= h_in.pfx ? 7'd2 : 7'd0;
      tot_r <= h_in.single ? 7'd1 : (blen + padn + (h_in.pfx ? 7'd2 : 7'd0));
    end
  end
  assign out_valid = ov_r;
  assign out_character = oc_r;
  assign out_last = ol_r;

  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_last)) else $error("stalled last changed");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character))
    else $error("stalled output changed");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pos_r < tot_r) else $error("position overrun");
endmodule
`default_nettype wire

FILE: sv/printf_number_formatter.sv
// Top level of the printf number formatter: decode, digit pipeline, emitter.
// Depends on pnf_pkg, pnf_decode, pnf_digits and pnf_emit.
// Usage: present a request on in_* with in_valid; it transfers when in_stall
// is low. Characters leave one per cycle while out_stall is low, on
// out_character, with out_last on the final one of each request; unknown
// opcodes give no characters. The front end is a 12-stage pipeline (decode
// plus one stage per digit) that moves while the emitter can take a new item.
// Throughput is one character per cycle while out_stall is low; a request
// has 1 character for percent and char, up to 2 + MAX_WIDTH otherwise, and
// the character sequencer sets that count.
// Reset is synchronous and clears all valid bits; no items are held.
// When the receiver stalls, the output register holds, the emitter stops and the
// pipeline stops once its last stage is full, raising in_stall; nothing is lost or repeated.
`default_nettype none
module printf_number_formatter import pnf_pkg::*; #(
  parameter int MAX_WIDTH = 62
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [31:0] in_value,
  input  wire logic [5:0]  in_field_width,
  input  wire logic        in_pad_zero,
  input  wire logic        in_left_justify,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_character,
  output logic             out_last
);
  logic en, take, dv, pv;
  req_t dq;
  hdr_t h;
  logic [NDIG*4-1:0] dg;
  logic [3:0] nd;

  assign en = take || !pv;
  assign in_stall = !en;

  pnf_decode #(.MAX_W(MAX_WIDTH)) u_dec (
    .clk, .rst_n, .en, .v_in(in_valid), .opcode(in_opcode), .value(in_value),
    .field_width(in_field_width), .pad_zero(in_pad_zero),
    .left_justify(in_left_justify), .v_r(dv), .q_r(dq));

  pnf_digits u_dig (.clk, .rst_n, .en, .v_in(dv), .d_in(dq), .v_out(pv),
    .h_out(h), .dig_out(dg), .ndig_out(nd));

  pnf_emit u_emit (.clk, .rst_n, .v_in(pv && en), .h_in(h), .dig_in(dg),
    .ndig_in(nd), .take, .out_valid, .out_stall, .out_character, .out_last);
endmodule
`default_nettype wire
